### rtl/core/mpss_pkg.sv
// ---------------------------------------------------------------------------
// mpss_pkg
// Shared types and constants of the multi-pattern substring search core.
// ---------------------------------------------------------------------------
package mpss_pkg;

  // default sizes
  localparam int MAX_PATTERNS_DEF = 16;
  localparam int MAX_LEN_DEF      = 16;

  // input function codes
  localparam logic [1:0] FUNC_PATTERN = 2'd0;
  localparam logic [1:0] FUNC_TEXT    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  // width of the reported pattern index
  localparam int OUT_IDX_W = 4;

  // report queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QLVL_W  = $clog2(QDEPTH + 1);

  // one input item
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       last;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic afull;
    logic empty;
  } qstat_t;

endpackage

### rtl/core/mpss_front.sv
// ---------------------------------------------------------------------------
// mpss_front
// Accepts items, holds the pattern store and the text window, compares the
// window against every closed pattern and hands end-of-text reports to the
// queue.
// ---------------------------------------------------------------------------
module mpss_front #(
  parameter int MAX_PATTERNS = mpss_pkg::MAX_PATTERNS_DEF,
  parameter int MAX_LEN      = mpss_pkg::MAX_LEN_DEF,
  parameter int JOB_W        = 2 * MAX_PATTERNS + $clog2(MAX_PATTERNS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mpss_pkg::item_t       item,
  input  mpss_pkg::qstat_t      qstat,
  output logic                  push,
  output logic [JOB_W-1:0]      push_data
);

  localparam int IDX_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
  localparam int LPOS_W = $clog2(MAX_LEN + 1);

  // pattern store: entry 0 holds the latest loaded byte of each pattern
  logic [MAX_PATTERNS-1:0][MAX_LEN-1:0][7:0] pat, pat_next;
  logic [MAX_PATTERNS-1:0][MAX_LEN-1:0]      mask, mask_next;
  logic [MAX_PATTERNS-1:0]                   ovf, ovf_next;
  logic [CNT_W-1:0]                          count, count_next;
  logic [LPOS_W-1:0]                         load_pos, load_pos_next;
  logic                                      open_ovf, open_ovf_next;

  // text window: entry 0 is the newest byte
  logic [MAX_LEN-1:0][7:0]                   win, win_next;
  logic [MAX_LEN-1:0]                        wv, wv_next;
  logic [MAX_PATTERNS-1:0]                   found, found_next;
  logic                                      text_pending, text_pending_next;
  logic                                      end_pending, end_pending_next;

  logic                                      accept, is_load, is_text, is_clear, room;
  logic [IDX_W-1:0]                          slot;
  logic [MAX_PATTERNS-1:0]                   hit;
  logic [MAX_PATTERNS-1:0]                   found_hit;

  // a third report must never be pushed into a full queue
  assign in_ready = !(qstat.full || (qstat.afull && end_pending));
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && (item.func == mpss_pkg::FUNC_PATTERN) &&
                    (count < CNT_W'(MAX_PATTERNS));
  assign is_text  = accept && (item.func == mpss_pkg::FUNC_TEXT);
  assign is_clear = accept && (item.func == mpss_pkg::FUNC_CLEAR);
  assign slot     = count[IDX_W-1:0];
  assign room     = load_pos < LPOS_W'(MAX_LEN);

  // window compare against every closed pattern
  always_comb begin
    logic [MAX_LEN-1:0] ok;
    for (int p = 0; p < MAX_PATTERNS; p++) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        ok[i] = !mask[p][i] || (wv[i] && (pat[p][i] == win[i]));
      end
      hit[p] = (CNT_W'(p) < count) && !ovf[p] && mask[p][0] && (&ok);
    end
  end

  assign found_hit = text_pending ? (found | hit) : found;

  // report to the back end in the cycle after the final text byte
  assign push      = end_pending;
  assign push_data = {count, ovf, found_hit};

  // next state
  always_comb begin
    pat_next          = pat;
    mask_next         = mask;
    ovf_next          = ovf;
    count_next        = count;
    load_pos_next     = load_pos;
    open_ovf_next     = open_ovf;
    win_next          = win;
    wv_next           = end_pending ? '0 : wv;
    found_next        = end_pending ? '0 : found_hit;
    text_pending_next = is_text;
    end_pending_next  = is_text && item.last;

    // shift a text byte into the window
    if (is_text) begin
      for (int i = 1; i < MAX_LEN; i++) begin
        win_next[i] = win[i-1];
        wv_next[i]  = end_pending ? 1'b0 : wv[i-1];
      end
      win_next[0] = item.data;
      wv_next[0]  = 1'b1;
    end

    // drop all patterns
    if (is_clear) begin
      found_next    = '0;
      count_next    = '0;
      load_pos_next = '0;
      open_ovf_next = 1'b0;
    end

    // load a pattern byte into the open slot
    if (is_load) begin
      if (room) begin
        for (int i = 1; i < MAX_LEN; i++) begin
          pat_next[slot][i]  = pat[slot][i-1];
          mask_next[slot][i] = (load_pos != '0) && mask[slot][i-1];
        end
        pat_next[slot][0]  = item.data;
        mask_next[slot][0] = 1'b1;
        load_pos_next      = load_pos + LPOS_W'(1);
      end else begin
        open_ovf_next = 1'b1;
      end
      if (item.last) begin
        ovf_next[slot]   = open_ovf || !room;
        found_next[slot] = 1'b0;
        count_next       = count + CNT_W'(1);
        load_pos_next    = '0;
        open_ovf_next    = 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pat  <= pat_next;
    mask <= mask_next;
    ovf  <= ovf_next;
    win  <= win_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      load_pos     <= '0;
      open_ovf     <= 1'b0;
      wv           <= '0;
      found        <= '0;
      text_pending <= 1'b0;
      end_pending  <= 1'b0;
    end else begin
      count        <= count_next;
      load_pos     <= load_pos_next;
      open_ovf     <= open_ovf_next;
      wv           <= wv_next;
      found        <= found_next;
      text_pending <= text_pending_next;
      end_pending  <= end_pending_next;
    end
  end

endmodule

### rtl/core/mpss_queue.sv
// ---------------------------------------------------------------------------
// mpss_queue
// Short report queue between the front end and the result sequencer.
// ---------------------------------------------------------------------------
module mpss_queue #(
  parameter int W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [W-1:0]      din,
  input  logic              pop,
  output logic [W-1:0]      dout,
  output mpss_pkg::qstat_t  qstat
);

  logic [W-1:0]                  mem [mpss_pkg::QDEPTH];
  logic [mpss_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [mpss_pkg::QLVL_W-1:0]   level;

  assign dout        = mem[rd_ptr];
  assign qstat.empty = (level == '0);
  assign qstat.full  = (level == mpss_pkg::QLVL_W'(mpss_pkg::QDEPTH));
  assign qstat.afull = (level >= mpss_pkg::QLVL_W'(mpss_pkg::QDEPTH - 1));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mpss_pkg::QPTR_W'(mpss_pkg::QDEPTH - 1)) ?
                  '0 : wr_ptr + mpss_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == mpss_pkg::QPTR_W'(mpss_pkg::QDEPTH - 1)) ?
                  '0 : rd_ptr + mpss_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + mpss_pkg::QLVL_W'(1);
      end else if (pop && !push) begin
        level <= level - mpss_pkg::QLVL_W'(1);
      end
    end
  end

endmodule

### rtl/core/mpss_back.sv
// ---------------------------------------------------------------------------
// mpss_back
// Result sequencer: walks a queued report and emits one result item per
// closed pattern through a registered output stage.
// ---------------------------------------------------------------------------
module mpss_back #(
  parameter int MAX_PATTERNS = mpss_pkg::MAX_PATTERNS_DEF,
  parameter int JOB_W        = 2 * MAX_PATTERNS + $clog2(MAX_PATTERNS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [JOB_W-1:0]   head,
  input  mpss_pkg::qstat_t   qstat,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,    // [3:0] pattern_index, [4] found, [5] too_long
  output logic               m_tlast     // last_result
);

  localparam int IDX_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int CNT_W = $clog2(MAX_PATTERNS + 1);

  logic [MAX_PATTERNS-1:0]        h_found, h_ovf;
  logic [CNT_W-1:0]               h_cnt;
  logic [IDX_W-1:0]               idx;
  logic [IDX_W+mpss_pkg::OUT_IDX_W-1:0] idx_wide;
  logic                           adv, take, at_end;

  assign h_found  = head[MAX_PATTERNS-1:0];
  assign h_ovf    = head[2*MAX_PATTERNS-1:MAX_PATTERNS];
  assign h_cnt    = head[JOB_W-1:2*MAX_PATTERNS];
  assign idx_wide = {{mpss_pkg::OUT_IDX_W{1'b0}}, idx};

  assign adv    = !m_tvalid || m_tready;
  assign take   = adv && !qstat.empty && (h_cnt != '0);
  assign at_end = (CNT_W'(idx) + CNT_W'(1)) == h_cnt;
  assign pop    = adv && !qstat.empty && ((h_cnt == '0) || at_end);

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {2'b00, h_ovf[idx], h_found[idx], idx_wide[mpss_pkg::OUT_IDX_W-1:0]};
      m_tlast <= at_end;
    end
  end

  // output valid and pattern counter
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (adv) begin
        m_tvalid <= take;
      end
      if (pop) begin
        idx <= '0;
      end else if (take) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

### rtl/core/multi_pattern_substring_search_core.sv
// ---------------------------------------------------------------------------
// multi_pattern_substring_search_core
// Multi-pattern substring search: pattern store, text window and results.
// ---------------------------------------------------------------------------
// The core takes one item per clock cycle on its input stream while it is
// not stalled: pattern bytes (tuser 0, tlast closes a pattern), text bytes
// (tuser 1, tlast ends the text) and a clear of all patterns (tuser 2). The
// window of the last MAX_LEN text bytes is compared against every closed
// pattern in parallel, in the cycle after the byte enters. On the final text
// byte a report goes into a two-entry queue, and the result sequencer then
// emits one result per closed pattern in load order, one per cycle while the
// output is taken. Input stalls while two reports wait in the queue, or while
// one waits and another text end has just been accepted.
// ---------------------------------------------------------------------------
module multi_pattern_substring_search_core #(
  parameter int MAX_PATTERNS = mpss_pkg::MAX_PATTERNS_DEF,
  parameter int MAX_LEN      = mpss_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data
  input  logic [1:0]  s_tuser,    // [1:0] func
  input  logic        s_tlast,    // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [3:0] pattern_index, [4] found, [5] too_long
  output logic        m_tlast     // last_result
);

  localparam int CNT_W = $clog2(MAX_PATTERNS + 1);
  localparam int JOB_W = 2 * MAX_PATTERNS + CNT_W;

  mpss_pkg::item_t   item;
  mpss_pkg::qstat_t  qstat;
  logic              push, pop;
  logic [JOB_W-1:0]  push_data, head;

  assign item.func = s_tuser;
  assign item.data = s_tdata;
  assign item.last = s_tlast;

  mpss_front #(
    .MAX_PATTERNS (MAX_PATTERNS),
    .MAX_LEN      (MAX_LEN),
    .JOB_W        (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  mpss_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (head),
    .qstat (qstat)
  );

  mpss_back #(
    .MAX_PATTERNS (MAX_PATTERNS),
    .JOB_W        (JOB_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### rtl/core/mpss_checker.sv
// ---------------------------------------------------------------------------
// mpss_checker
// Port-level checks of the result stream of the search core.
// ---------------------------------------------------------------------------
module mpss_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic [3:0] exp_idx;

  // expected pattern index of the next result
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      exp_idx <= m_tlast ? 4'd0 : m_tdata[3:0] + 4'd1;
    end
  end

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // results of a run count up from zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] == exp_idx)
    else $error("pattern index out of sequence");

  // an overlong pattern never matches
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[4] && m_tdata[5]))
    else $error("overlong pattern reported as found");

  // no result straight out of reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind multi_pattern_substring_search_core mpss_checker u_mpss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
